// ===== sv/assert_macros.svh =====
// Assertion helpers. Each use samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check while out of reset.
`define DM2_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check at every edge, reset included.
`define DM2_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define DM2_ASSERT(lbl, prop, msg)
`define DM2_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/dm2_pkg.sv =====
package dm2_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam int          MIX_SHIFT   = 24;
   localparam int          FIN_SHIFT_A = 13;
   localparam int          FIN_SHIFT_B = 15;

   localparam logic [31:0] SEED_LOW_RESET  = 32'hF835E195;
   localparam logic [31:0] SEED_HIGH_RESET = 32'h5C285D21;

   localparam int          LEN_W   = 31;
   localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};

   // Register map: register i at byte address 4*i.
   localparam int          CSR_AW        = 3;
   localparam logic        CSR_SEED_LOW  = 1'b0;
   localparam logic        CSR_SEED_HIGH = 1'b1;

   localparam int          QUEUE_DEPTH = 4;
   localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int          QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // One command from the front to the hash engine.
   typedef struct packed {
      logic             start;       // restart both hashes from seed ^ length
      logic [LEN_W-1:0] length;
      logic             mix;         // mix a complete word
      logic [31:0]      word;
      logic             fin;         // finalize and emit
      logic             tail_valid;  // 1 to 3 tail bytes present
      logic [23:0]      tail;
      logic             mismatch;
   } cmd_type;

endpackage

// ===== sv/dm2_front.sv =====
module dm2_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [7:0]                 req_data_byte,
   input  logic [dm2_pkg::LEN_W-1:0]  req_message_length,
   input  logic                       req_first_item,
   input  logic                       req_last_item,
   input  logic                       req_no_data,
   output logic                       q_push,
   output dm2_pkg::cmd_type           q_data,
   input  logic                       q_full
);

   logic [dm2_pkg::LEN_W-1:0] decl_ff, decl_in;
   logic [23:0]               pw_ff, pw_in;
   logic [1:0]                biw_ff, biw_in;
   logic [dm2_pkg::LEN_W-1:0] cnt_ff, cnt_in;

   logic                      accept;
   logic [dm2_pkg::LEN_W-1:0] decl;
   logic [23:0]               pw;
   logic [1:0]                biw;
   logic [dm2_pkg::LEN_W-1:0] cnt;

   assign full   = q_full;
   assign accept = push & ~q_full;

   always_comb begin
      decl = req_first_item ? req_message_length : decl_ff;
      pw   = req_first_item ? 24'd0 : pw_ff;
      biw  = req_first_item ? 2'd0 : biw_ff;
      cnt  = req_first_item ? '0 : cnt_ff;

      q_data            = '0;
      q_data.start      = req_first_item;
      q_data.length     = req_message_length;
      q_data.word       = {req_data_byte, pw};

      pw_in  = pw;
      biw_in = biw;
      cnt_in = cnt;
      if (!req_no_data) begin
         if (biw == 2'd3) begin
            q_data.mix = 1'b1;
            pw_in      = 24'd0;
            biw_in     = 2'd0;
         end else begin
            case (biw)
               2'd0:    pw_in = {pw[23:8], req_data_byte};
               2'd1:    pw_in = {pw[23:16], req_data_byte, pw[7:0]};
               default: pw_in = {req_data_byte, pw[15:0]};
            endcase
            biw_in = biw + 2'd1;
         end
         if (cnt != dm2_pkg::COUNT_MAX) begin
            cnt_in = cnt + 1'b1;
         end
      end

      decl_in = decl;
      if (req_last_item) begin
         q_data.fin        = 1'b1;
         q_data.tail_valid = (biw_in != 2'd0);
         q_data.tail       = pw_in;
         q_data.mismatch   = (cnt_in != decl);
         // re-arm as a zero-length message
         decl_in = '0;
         pw_in   = 24'd0;
         biw_in  = 2'd0;
         cnt_in  = '0;
      end

      q_push = accept & (q_data.start | q_data.mix | q_data.fin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= '0;
         pw_ff   <= '0;
         biw_ff  <= '0;
         cnt_ff  <= '0;
      end else if (accept) begin
         decl_ff <= decl_in;
         pw_ff   <= pw_in;
         biw_ff  <= biw_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== sv/dm2_fifo.sv =====
`include "assert_macros.svh"

module dm2_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  dm2_pkg::cmd_type  wr_data,
   output logic              full,
   input  logic              rd_en,
   output dm2_pkg::cmd_type  rd_data,
   output logic              empty
);

   dm2_pkg::cmd_type                 slot_ff [dm2_pkg::QUEUE_DEPTH];
   logic [dm2_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [dm2_pkg::QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [dm2_pkg::QUEUE_CW-1:0]     count_ff, count_in;
   logic                             do_wr, do_rd;

   assign full    = (count_ff == dm2_pkg::QUEUE_CW'(dm2_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `DM2_ASSERT(a_count_bound, count_ff <= dm2_pkg::QUEUE_CW'(dm2_pkg::QUEUE_DEPTH), "queue count overflow")
   `DM2_ASSERT(a_ptr_count, (wr_ptr_ff - rd_ptr_ff) == count_ff[dm2_pkg::QUEUE_AW-1:0], "queue pointers disagree with count")

endmodule

// ===== sv/dm2_back.sv =====
`include "assert_macros.svh"

module dm2_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       seed_low,
   input  logic [31:0]       seed_high,
   input  dm2_pkg::cmd_type  q_data,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output logic [63:0]       rsp_hash_value,
   output logic              rsp_length_mismatch
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_K2   = 4'd1;
   localparam logic [3:0] ST_HL   = 4'd2;
   localparam logic [3:0] ST_HH   = 4'd3;
   localparam logic [3:0] ST_TL   = 4'd4;
   localparam logic [3:0] ST_TH   = 4'd5;
   localparam logic [3:0] ST_FL   = 4'd6;
   localparam logic [3:0] ST_FH   = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [31:0] hlo_ff, hlo_in;
   logic [31:0] hhi_ff, hhi_in;
   logic [31:0] k_ff, k_in;
   logic        fin_ff, fin_in;
   logic        tv_ff, tv_in;
   logic [23:0] tail_ff, tail_in;
   logic        mis_ff, mis_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;
   logic        rsp_mis_ff, rsp_mis_in;

   logic [31:0] mul_a;
   logic [31:0] product;
   logic        slot_free;

   assign slot_free           = ~rsp_valid_ff | pop;
   assign empty               = ~rsp_valid_ff;
   assign rsp_hash_value      = rsp_hash_ff;
   assign rsp_length_mismatch = rsp_mis_ff;

   // one shared multiplier, operand picked by step
   always_comb begin
      case (state_ff)
         ST_IDLE: mul_a = q_data.word;
         ST_K2:   mul_a = k_ff ^ (k_ff >> dm2_pkg::MIX_SHIFT);
         ST_HL:   mul_a = hlo_ff;
         ST_HH:   mul_a = hhi_ff;
         ST_TL:   mul_a = hlo_ff ^ {8'd0, tail_ff};
         ST_TH:   mul_a = hhi_ff ^ {8'd0, tail_ff};
         ST_FL:   mul_a = hlo_ff ^ (hlo_ff >> dm2_pkg::FIN_SHIFT_A);
         ST_FH:   mul_a = hhi_ff ^ (hhi_ff >> dm2_pkg::FIN_SHIFT_A);
         default: mul_a = 32'd0;
      endcase
      product = mul_a * dm2_pkg::MIX_MUL;
   end

   always_comb begin
      state_in     = state_ff;
      hlo_in       = hlo_ff;
      hhi_in       = hhi_ff;
      k_in         = k_ff;
      fin_in       = fin_ff;
      tv_in        = tv_ff;
      tail_in      = tail_ff;
      mis_in       = mis_ff;
      rsp_valid_in = rsp_valid_ff & ~pop;
      rsp_hash_in  = rsp_hash_ff;
      rsp_mis_in   = rsp_mis_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               k_in    = product;
               fin_in  = q_data.fin;
               tv_in   = q_data.tail_valid;
               tail_in = q_data.tail;
               mis_in  = q_data.mismatch;
               if (q_data.start) begin
                  hlo_in = seed_low ^ {1'b0, q_data.length};
                  hhi_in = seed_high ^ {1'b0, q_data.length};
               end
               if (q_data.mix) begin
                  state_in = ST_K2;
               end else if (q_data.fin) begin
                  state_in = ST_TL;
               end
            end
         end
         ST_K2: begin
            k_in     = product;
            state_in = ST_HL;
         end
         ST_HL: begin
            hlo_in   = product ^ k_ff;
            state_in = ST_HH;
         end
         ST_HH: begin
            hhi_in   = product ^ k_ff;
            state_in = fin_ff ? ST_TL : ST_IDLE;
         end
         ST_TL: begin
            if (tv_ff) begin
               hlo_in = product;
            end
            state_in = ST_TH;
         end
         ST_TH: begin
            if (tv_ff) begin
               hhi_in = product;
            end
            state_in = ST_FL;
         end
         ST_FL: begin
            hlo_in   = product;
            state_in = ST_FH;
         end
         ST_FH: begin
            hhi_in   = product;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the result register frees, then re-arm from the seeds
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = {hhi_ff ^ (hhi_ff >> dm2_pkg::FIN_SHIFT_B),
                               hlo_ff ^ (hlo_ff >> dm2_pkg::FIN_SHIFT_B)};
               rsp_mis_in   = mis_ff;
               hlo_in       = seed_low;
               hhi_in       = seed_high;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hlo_ff       <= '0;
         hhi_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hlo_ff       <= hlo_in;
         hhi_ff       <= hhi_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      fin_ff      <= fin_in;
      tv_ff       <= tv_in;
      tail_ff     <= tail_in;
      mis_ff      <= mis_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_mis_ff  <= rsp_mis_in;
   end

   `DM2_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE) && !rsp_valid_ff, "engine not idle after reset")
   `DM2_ASSERT(a_out_load, (state_ff == ST_OUT) && slot_free |=> (state_ff == ST_IDLE) && rsp_valid_ff, "finished hash not delivered")
   `DM2_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT, "result appeared outside output step")

endmodule

// ===== sv/dual_murmur2_neutral_hash64.sv =====
// Path: a last word reaches the result ports through the 4-entry queue and the engine steps (K2,
// HL, HH if it completes a 4-byte word; then TL, TH, FL, FH, OUT), behind any commands queued ahead of it.
// Throughput: one byte per cycle at the input while the 4-entry queue has room; the shared
// multiplier in the hash engine serves each complete word in IDLE, K2, HL, HH and each finalization
// in TL, TH, FL, FH; the engine pops only in IDLE, and the output step holds while an unread result waits.
// Reset: synchronous, active high; clears both hashes and counters, seeds take their defaults.
`include "assert_macros.svh"

module dual_murmur2_neutral_hash64 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [7:0]                  req_data_byte,
   input  logic [dm2_pkg::LEN_W-1:0]   req_message_length,
   input  logic                        req_first_item,
   input  logic                        req_last_item,
   input  logic                        req_no_data,
   output logic                        empty,
   input  logic                        pop,
   output logic [63:0]                 rsp_hash_value,
   output logic                        rsp_length_mismatch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [dm2_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic [31:0]      seed_low_ff, seed_low_in;
   logic [31:0]      seed_high_ff, seed_high_in;
   logic             csr_wr;
   logic             q_push, q_full, q_pop, q_empty;
   dm2_pkg::cmd_type q_wdata, q_rdata;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      seed_low_in  = seed_low_ff;
      seed_high_in = seed_high_ff;
      if (csr_wr) begin
         case (paddr[2])
            dm2_pkg::CSR_SEED_LOW:  seed_low_in  = pwdata;
            dm2_pkg::CSR_SEED_HIGH: seed_high_in = pwdata;
            default:                seed_low_in  = seed_low_ff;
         endcase
      end
      case (paddr[2])
         dm2_pkg::CSR_SEED_LOW:  prdata = seed_low_ff;
         dm2_pkg::CSR_SEED_HIGH: prdata = seed_high_ff;
         default:                prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_low_ff  <= dm2_pkg::SEED_LOW_RESET;
         seed_high_ff <= dm2_pkg::SEED_HIGH_RESET;
      end else begin
         seed_low_ff  <= seed_low_in;
         seed_high_ff <= seed_high_in;
      end
   end

   dm2_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_data_byte      (req_data_byte),
      .req_message_length (req_message_length),
      .req_first_item     (req_first_item),
      .req_last_item      (req_last_item),
      .req_no_data        (req_no_data),
      .q_push             (q_push),
      .q_data             (q_wdata),
      .q_full             (q_full)
   );

   dm2_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wdata),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rdata),
      .empty   (q_empty)
   );

   dm2_back u_back (
      .clock               (clock),
      .reset               (reset),
      .seed_low            (seed_low_ff),
      .seed_high           (seed_high_ff),
      .q_data              (q_rdata),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .empty               (empty),
      .pop                 (pop),
      .rsp_hash_value      (rsp_hash_value),
      .rsp_length_mismatch (rsp_length_mismatch)
   );

endmodule
